[src/sogi_single_phase_pll_assert.svh]
// ----------------------------------------------------------------------------
// SOGI PLL assertion macros
// Shorthand for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef SOGI_SINGLE_PHASE_PLL_ASSERT_SVH
`define SOGI_SINGLE_PHASE_PLL_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define SPLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds during reset.
`define SPLL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/spll_pkg.sv]
// ----------------------------------------------------------------------------
// SOGI PLL package
// Shared types, register indexes, constants and helper functions.
// ----------------------------------------------------------------------------
package spll_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

  // Operation steps of one sample.
  typedef enum logic [4:0] {
    SP_FLT_B0, SP_FLT_A1V, SP_FLT_A2V, SP_FLT_B1, SP_FLT_A1Q, SP_FLT_A2Q,
    SP_SIN_X, SP_SIN_X2, SP_SIN_TM, SP_SIN_TD, SP_SIN_S,
    SP_ERR_VC, SP_ERR_QS,
    SP_PI_IGSP, SP_PI_INC, SP_PI_PROP,
    SP_FRQ, SP_PH_WT, SP_PH_STEP, SP_DUTY
  } step_t;

  // Which sine evaluation is running.
  typedef enum logic [1:0] {SIN_OLD, SIN_COS, SIN_NEW} sin_pass_t;

  // Register indexes.
  localparam logic [2:0] REG_COEF_B0       = 3'd0;
  localparam logic [2:0] REG_COEF_B1       = 3'd1;
  localparam logic [2:0] REG_COEF_A1       = 3'd2;
  localparam logic [2:0] REG_COEF_A2       = 3'd3;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd4;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd5;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd6;
  localparam logic [2:0] REG_NOMINAL_OMEGA = 3'd7;

  // Register reset values.
  localparam logic signed [31:0] RST_COEF_B0 = 32'sd5694171;
  localparam logic signed [31:0] RST_COEF_B1 = 32'sd21464;
  localparam logic signed [31:0] RST_COEF_A1 = -32'sd2136034427;
  localparam logic signed [31:0] RST_COEF_A2 = 32'sd1062353493;
  localparam logic [31:0] RST_PROP_GAIN     = 32'd10485760;
  localparam logic [31:0] RST_INTEG_GAIN    = 32'd1310720000;
  localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd85899;
  localparam logic [30:0] RST_NOMINAL_OMEGA = 31'd1581215353;

  // Fixed-point constants.
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] INV_TWO_PI  = 32'd683565276;
  localparam logic signed [41:0] INTEG_LIMIT = 42'sd263535892;
  localparam logic signed [51:0] W_CLAMP_HI  = 52'sd1712983302;
  localparam logic signed [51:0] W_CLAMP_LO  = 52'sd1185911518;
  localparam logic [63:0] DUTY_GAIN   = 64'd800;
  localparam logic signed [96:0] DUTY_BIAS = 97'sd1000 <<< 30;
  localparam logic [2:0]  SIN_TERMS   = 3'd4;
  localparam logic signed [96:0] SAT_HI = 97'sd2147483647;
  localparam logic signed [96:0] SAT_LO = -97'sd2147483648;

  // Magnitude of a signed 32-bit value.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [96:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

  // Divisors of the sine series, innermost first.
  function automatic logic [6:0] sine_div(input logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

endpackage

[src/spll_mul.sv]
// ----------------------------------------------------------------------------
// SOGI PLL serial multiplier
// Unsigned 64 x 32 multiply, two multiplier bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module spll_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [95:0] prod
);

  logic        busy;
  logic [3:0]  cnt;
  logic [95:0] acc;
  logic [31:0] bsh;
  logic [63:0] am;
  logic [65:0] a3;
  logic [95:0] addend;

  // Partial product of the current radix-4 digit.
  always_comb begin
    case (bsh[31:30])
      2'd0:    addend = '0;
      2'd1:    addend = 96'(am);
      2'd2:    addend = 96'({am, 1'b0});
      default: addend = 96'(a3);
    endcase
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 4'd15);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) busy <= 1'b0;
      end
    end
  end

  // Shift-and-add datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      am  <= a;
      a3  <= 66'(a) + {1'b0, a, 1'b0};
      bsh <= b;
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[93:0], 2'b00} + addend;
      bsh <= {bsh[29:0], 2'b00};
    end
  end

  assign prod = acc;

endmodule

[src/spll_div.sv]
// ----------------------------------------------------------------------------
// SOGI PLL serial divider
// Unsigned 32-bit by 7-bit restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module spll_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [6:0]  den,
  output logic        done,
  output logic [31:0] quo
);

  logic       busy;
  logic [3:0] cnt;
  logic [31:0] nsh;
  logic [6:0] dreg;
  logic [6:0] rem;
  logic [7:0] t1, t2;
  logic       ge1, ge2;
  logic [6:0] r1, r2;

  // Two dependent restoring steps.
  always_comb begin
    t1  = {rem, nsh[31]};
    ge1 = t1 >= {1'b0, dreg};
    r1  = ge1 ? 7'(t1 - {1'b0, dreg}) : 7'(t1);
    t2  = {r1, nsh[30]};
    ge2 = t2 >= {1'b0, dreg};
    r2  = ge2 ? 7'(t2 - {1'b0, dreg}) : 7'(t2);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 4'd15);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) busy <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      nsh <= {nsh[29:0], 2'b00};
      rem <= r2;
      quo <= {quo[29:0], ge1, ge2};
    end
  end

endmodule

[src/sogi_single_phase_pll.sv]
// ----------------------------------------------------------------------------
// SOGI single-phase PLL
// Grid synchronizer: SOGI quadrature filter, phase detector, PI loop filter,
// phase accumulator and PWM compare value, computed with serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one grid sample per transfer (s_tdata[15:0], Q2.14).
//   Output stream m_*: one result per sample, packed in m_tdata.
//   APB port: eight tuning registers at byte addresses 0x00 to 0x1C.
// Sequencing:
//   Each sample runs 39 multiplications on the shared radix-4 serial
//   multiplier and 15 divisions on the serial divider, one at a time,
//   between the sample accept and the output register load.
//   The multiplier and divider set how long one sample takes.
//   s_tready is high only while the sequencer is idle.
// Reset:
//   rst clears the filter history, integrator and phase, and loads the
//   register defaults. No output is pending after reset.
// Stall:
//   A finished result sits in the output register; the next sample is
//   accepted meanwhile. A second result waits until the first transfer.
// ----------------------------------------------------------------------------
module sogi_single_phase_pll #(
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  // Fields: grid_sample[15:0]
  input  logic [15:0]  s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Fields: inphase_out[31:0], quadrature_out[63:32], phase_error[95:64],
  // phase_angle[127:96], frequency_hz[150:128], duty_compare[161:151]
  output logic [167:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [31:0] SINE_MASK =
    ~((32'd1 << (32 - SINE_TABLE_ADDR_BITS)) - 32'd1);

  // Configuration registers.
  logic signed [31:0] coef_b0, coef_b1, coef_a1, coef_a2;
  logic [31:0] prop_gain, integ_gain, sample_period;
  logic [30:0] nominal_omega;

  // Loop state.
  logic signed [15:0] sample_delay1, sample_delay2, x;
  logic signed [31:0] inphase_delay1, inphase_delay2, quad_delay1, quad_delay2;
  logic signed [31:0] integrator;
  logic [31:0] phase_accum;

  // Work registers.
  spll_pkg::state_t    state, state_next;
  spll_pkg::step_t     step, step_next;
  spll_pkg::sin_pass_t spass;
  logic [2:0]  sk;
  logic signed [63:0] facc, eacc;
  logic signed [31:0] vp, qvp, err, sn, cs, sn2;
  logic [31:0] sx, sx2, st, tm;
  logic [63:0] igsp, wt;
  logic [30:0] omega;
  logic [22:0] freq;
  logic [10:0] duty;

  // Arithmetic units.
  logic        mul_start, mul_done, div_start, div_done, unit_done;
  logic [63:0] op_a;
  logic [31:0] op_b;
  logic        op_neg, prod_neg;
  logic [95:0] prod;
  logic [31:0] quo;
  logic signed [96:0] prod_s;

  // Derived values.
  logic signed [16:0] fx0_n;
  logic signed [17:0] fx1_n;
  logic signed [31:0] fx0, fx1;
  logic [31:0] sin_ph, sin_pt;
  logic [30:0] sin_r;
  logic [31:0] sin_s;
  logic signed [31:0] sin_res;
  logic signed [63:0] facc_sub, flt_rnd;
  logic signed [96:0] err_sum, duty_sum;
  logic        err_neg;
  logic [31:0] err_mag;
  logic [39:0] inc;
  logic signed [41:0] integ_sum, integ_clamp;
  logic [47:0] prop;
  logic signed [51:0] omega_sum, omega_clamp;
  logic cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0       <= spll_pkg::RST_COEF_B0;
      coef_b1       <= spll_pkg::RST_COEF_B1;
      coef_a1       <= spll_pkg::RST_COEF_A1;
      coef_a2       <= spll_pkg::RST_COEF_A2;
      prop_gain     <= spll_pkg::RST_PROP_GAIN;
      integ_gain    <= spll_pkg::RST_INTEG_GAIN;
      sample_period <= spll_pkg::RST_SAMPLE_PERIOD;
      nominal_omega <= spll_pkg::RST_NOMINAL_OMEGA;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        spll_pkg::REG_COEF_B0:       coef_b0       <= pwdata;
        spll_pkg::REG_COEF_B1:       coef_b1       <= pwdata;
        spll_pkg::REG_COEF_A1:       coef_a1       <= pwdata;
        spll_pkg::REG_COEF_A2:       coef_a2       <= pwdata;
        spll_pkg::REG_PROP_GAIN:     prop_gain     <= pwdata;
        spll_pkg::REG_INTEG_GAIN:    integ_gain    <= pwdata;
        spll_pkg::REG_SAMPLE_PERIOD: sample_period <= pwdata;
        default:                     nominal_omega <= pwdata[30:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      spll_pkg::REG_COEF_B0:       prdata = coef_b0;
      spll_pkg::REG_COEF_B1:       prdata = coef_b1;
      spll_pkg::REG_COEF_A1:       prdata = coef_a1;
      spll_pkg::REG_COEF_A2:       prdata = coef_a2;
      spll_pkg::REG_PROP_GAIN:     prdata = prop_gain;
      spll_pkg::REG_INTEG_GAIN:    prdata = integ_gain;
      spll_pkg::REG_SAMPLE_PERIOD: prdata = sample_period;
      default:                     prdata = {1'b0, nominal_omega};
    endcase
  end

  // Shared units.
  assign mul_start = (state == spll_pkg::ST_ISSUE) && (step != spll_pkg::SP_SIN_TD);
  assign div_start = (state == spll_pkg::ST_ISSUE) && (step == spll_pkg::SP_SIN_TD);
  assign unit_done = mul_done || div_done;

  spll_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  spll_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (tm),
    .den   (spll_pkg::sine_div(sk)),
    .done  (div_done),
    .quo   (quo)
  );

  // Filter input combinations and sine argument.
  always_comb begin
    fx0_n = 17'(x) - 17'(sample_delay2);
    fx1_n = 18'(x) + (18'(sample_delay1) <<< 1) + 18'(sample_delay2);
    fx0   = 32'(fx0_n);
    fx1   = 32'(fx1_n);
    sin_ph = (spass == spll_pkg::SIN_COS) ? phase_accum + spll_pkg::ONE_Q30 : phase_accum;
    sin_pt = sin_ph & SINE_MASK;
    sin_r  = sin_pt[30] ? 31'(spll_pkg::ONE_Q30) - {1'b0, sin_pt[29:0]}
                        : {1'b0, sin_pt[29:0]};
  end

  // Operand selection for the multiplier.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    unique case (step)
      spll_pkg::SP_FLT_B0: begin
        op_a = 64'(spll_pkg::abs32(coef_b0)); op_b = spll_pkg::abs32(fx0);
        op_neg = coef_b0[31] ^ fx0[31];
      end
      spll_pkg::SP_FLT_A1V: begin
        op_a = 64'(spll_pkg::abs32(coef_a1)); op_b = spll_pkg::abs32(inphase_delay1);
        op_neg = coef_a1[31] ^ inphase_delay1[31];
      end
      spll_pkg::SP_FLT_A2V: begin
        op_a = 64'(spll_pkg::abs32(coef_a2)); op_b = spll_pkg::abs32(inphase_delay2);
        op_neg = coef_a2[31] ^ inphase_delay2[31];
      end
      spll_pkg::SP_FLT_B1: begin
        op_a = 64'(spll_pkg::abs32(coef_b1)); op_b = spll_pkg::abs32(fx1);
        op_neg = coef_b1[31] ^ fx1[31];
      end
      spll_pkg::SP_FLT_A1Q: begin
        op_a = 64'(spll_pkg::abs32(coef_a1)); op_b = spll_pkg::abs32(quad_delay1);
        op_neg = coef_a1[31] ^ quad_delay1[31];
      end
      spll_pkg::SP_FLT_A2Q: begin
        op_a = 64'(spll_pkg::abs32(coef_a2)); op_b = spll_pkg::abs32(quad_delay2);
        op_neg = coef_a2[31] ^ quad_delay2[31];
      end
      spll_pkg::SP_SIN_X: begin
        op_a = 64'(sin_r); op_b = spll_pkg::HALF_PI_Q30;
      end
      spll_pkg::SP_SIN_X2: begin
        op_a = 64'(sx); op_b = sx;
      end
      spll_pkg::SP_SIN_TM: begin
        op_a = 64'(sx2); op_b = st;
      end
      spll_pkg::SP_SIN_S: begin
        op_a = 64'(sx); op_b = st;
      end
      spll_pkg::SP_ERR_VC: begin
        op_a = 64'(spll_pkg::abs32(vp)); op_b = spll_pkg::abs32(cs);
        op_neg = vp[31] ^ cs[31];
      end
      spll_pkg::SP_ERR_QS: begin
        op_a = 64'(spll_pkg::abs32(qvp)); op_b = spll_pkg::abs32(sn);
        op_neg = qvp[31] ^ sn[31];
      end
      spll_pkg::SP_PI_IGSP: begin
        op_a = 64'(integ_gain); op_b = sample_period;
      end
      spll_pkg::SP_PI_INC: begin
        op_a = igsp; op_b = err_mag;
      end
      spll_pkg::SP_PI_PROP: begin
        op_a = 64'(prop_gain); op_b = err_mag;
      end
      spll_pkg::SP_FRQ: begin
        op_a = 64'(omega); op_b = spll_pkg::INV_TWO_PI;
      end
      spll_pkg::SP_PH_WT: begin
        op_a = 64'(omega); op_b = sample_period;
      end
      spll_pkg::SP_PH_STEP: begin
        op_a = wt; op_b = spll_pkg::INV_TWO_PI;
      end
      spll_pkg::SP_DUTY: begin
        op_a = spll_pkg::DUTY_GAIN; op_b = spll_pkg::abs32(sn2);
        op_neg = sn2[31];
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Result post-processing.
  always_comb begin
    prod_s   = prod_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    facc_sub = facc - 64'(prod_s >>> 16);
    flt_rnd  = (facc_sub + 64'sd8192) >>> 14;
    sin_s    = 32'(prod >> 30);
    sin_res  = sin_pt[31] ? -$signed(sin_s) : $signed(sin_s);
    err_sum  = 97'(eacc) + prod_s;
    err_neg  = err[31];
    err_mag  = spll_pkg::abs32(err);
    inc      = prod[95:56];
    integ_sum = 42'(integrator) + (err_neg ? -$signed({2'b00, inc}) : $signed({2'b00, inc}));
    if (integ_sum > spll_pkg::INTEG_LIMIT) integ_clamp = spll_pkg::INTEG_LIMIT;
    else if (integ_sum < -spll_pkg::INTEG_LIMIT) integ_clamp = -spll_pkg::INTEG_LIMIT;
    else integ_clamp = integ_sum;
    prop = prod[71:24];
    omega_sum = $signed({21'd0, nominal_omega}) + 52'(integrator)
              + (err_neg ? -$signed({4'd0, prop}) : $signed({4'd0, prop}));
    if (omega_sum > spll_pkg::W_CLAMP_HI) omega_clamp = spll_pkg::W_CLAMP_HI;
    else if (omega_sum < spll_pkg::W_CLAMP_LO) omega_clamp = spll_pkg::W_CLAMP_LO;
    else omega_clamp = omega_sum;
    duty_sum = spll_pkg::DUTY_BIAS + prod_s;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spll_pkg::ST_IDLE;
      step  <= spll_pkg::SP_FLT_B0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and step.
  always_comb begin
    state_next = state;
    step_next  = step;
    s_tready   = 1'b0;
    unique case (state)
      spll_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = spll_pkg::ST_ISSUE;
          step_next  = spll_pkg::SP_FLT_B0;
        end
      end
      spll_pkg::ST_ISSUE: begin
        state_next = spll_pkg::ST_WAIT;
      end
      spll_pkg::ST_WAIT: begin
        if (unit_done) begin
          state_next = spll_pkg::ST_ISSUE;
          unique case (step)
            spll_pkg::SP_FLT_B0:  step_next = spll_pkg::SP_FLT_A1V;
            spll_pkg::SP_FLT_A1V: step_next = spll_pkg::SP_FLT_A2V;
            spll_pkg::SP_FLT_A2V: step_next = spll_pkg::SP_FLT_B1;
            spll_pkg::SP_FLT_B1:  step_next = spll_pkg::SP_FLT_A1Q;
            spll_pkg::SP_FLT_A1Q: step_next = spll_pkg::SP_FLT_A2Q;
            spll_pkg::SP_FLT_A2Q: step_next = spll_pkg::SP_SIN_X;
            spll_pkg::SP_SIN_X:   step_next = spll_pkg::SP_SIN_X2;
            spll_pkg::SP_SIN_X2:  step_next = spll_pkg::SP_SIN_TM;
            spll_pkg::SP_SIN_TM:  step_next = spll_pkg::SP_SIN_TD;
            spll_pkg::SP_SIN_TD:
              step_next = (sk == spll_pkg::SIN_TERMS) ? spll_pkg::SP_SIN_S
                                                      : spll_pkg::SP_SIN_TM;
            spll_pkg::SP_SIN_S: begin
              unique case (spass)
                spll_pkg::SIN_OLD: step_next = spll_pkg::SP_SIN_X;
                spll_pkg::SIN_COS: step_next = spll_pkg::SP_ERR_VC;
                default:           state_next = spll_pkg::ST_ISSUE;
              endcase
              if (spass == spll_pkg::SIN_NEW) step_next = spll_pkg::SP_DUTY;
            end
            spll_pkg::SP_ERR_VC:  step_next = spll_pkg::SP_ERR_QS;
            spll_pkg::SP_ERR_QS:  step_next = spll_pkg::SP_PI_IGSP;
            spll_pkg::SP_PI_IGSP: step_next = spll_pkg::SP_PI_INC;
            spll_pkg::SP_PI_INC:  step_next = spll_pkg::SP_PI_PROP;
            spll_pkg::SP_PI_PROP: step_next = spll_pkg::SP_FRQ;
            spll_pkg::SP_FRQ:     step_next = spll_pkg::SP_PH_WT;
            spll_pkg::SP_PH_WT:   step_next = spll_pkg::SP_PH_STEP;
            spll_pkg::SP_PH_STEP: step_next = spll_pkg::SP_SIN_X;
            default:              state_next = spll_pkg::ST_OUT;
          endcase
        end
      end
      default: begin
        if (!m_tvalid || m_tready) state_next = spll_pkg::ST_IDLE;
      end
    endcase
  end

  // Loop state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_delay1  <= '0;
      sample_delay2  <= '0;
      inphase_delay1 <= '0;
      inphase_delay2 <= '0;
      quad_delay1    <= '0;
      quad_delay2    <= '0;
      integrator     <= '0;
      phase_accum    <= '0;
      m_tvalid       <= 1'b0;
      spass          <= spll_pkg::SIN_OLD;
      sk             <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == spll_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end
      if (state == spll_pkg::ST_IDLE && s_tvalid) spass <= spll_pkg::SIN_OLD;
      if (state == spll_pkg::ST_WAIT && unit_done) begin
        case (step)
          spll_pkg::SP_FLT_A2Q: begin
            sample_delay2  <= sample_delay1;
            sample_delay1  <= x;
            inphase_delay2 <= inphase_delay1;
            inphase_delay1 <= vp;
            quad_delay2    <= quad_delay1;
            quad_delay1    <= spll_pkg::sat32(97'(flt_rnd));
          end
          spll_pkg::SP_SIN_X2:  sk <= '0;
          spll_pkg::SP_SIN_TD:  sk <= sk + 3'd1;
          spll_pkg::SP_SIN_S:
            if (spass == spll_pkg::SIN_OLD) spass <= spll_pkg::SIN_COS;
          spll_pkg::SP_PI_INC:  integrator <= 32'(integ_clamp);
          spll_pkg::SP_PH_STEP: begin
            phase_accum <= phase_accum + 32'(prod >> 54);
            spass       <= spll_pkg::SIN_NEW;
          end
          default: begin
            sk <= sk;
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == spll_pkg::ST_IDLE && s_tvalid) x <= s_tdata;
    if (state == spll_pkg::ST_ISSUE) prod_neg <= op_neg;
    if (state == spll_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, duty, freq, phase_accum, err, qvp, vp};
    end
    if (state == spll_pkg::ST_WAIT && unit_done) begin
      case (step)
        spll_pkg::SP_FLT_B0, spll_pkg::SP_FLT_B1: facc <= prod_s[63:0];
        spll_pkg::SP_FLT_A1V, spll_pkg::SP_FLT_A1Q: facc <= facc_sub;
        spll_pkg::SP_FLT_A2V: vp  <= spll_pkg::sat32(97'(flt_rnd));
        spll_pkg::SP_FLT_A2Q: qvp <= spll_pkg::sat32(97'(flt_rnd));
        spll_pkg::SP_SIN_X:   sx  <= 32'(prod >> 30);
        spll_pkg::SP_SIN_X2: begin
          sx2 <= 32'(prod >> 30);
          st  <= spll_pkg::ONE_Q30;
        end
        spll_pkg::SP_SIN_TM:  tm <= 32'(prod >> 30);
        spll_pkg::SP_SIN_TD:  st <= spll_pkg::ONE_Q30 - quo;
        spll_pkg::SP_SIN_S: begin
          case (spass)
            spll_pkg::SIN_OLD: sn  <= sin_res;
            spll_pkg::SIN_COS: cs  <= sin_res;
            default:           sn2 <= sin_res;
          endcase
        end
        spll_pkg::SP_ERR_VC:  eacc  <= prod_s[63:0];
        spll_pkg::SP_ERR_QS:  err   <= spll_pkg::sat32(err_sum >>> 30);
        spll_pkg::SP_PI_IGSP: igsp  <= prod[63:0];
        spll_pkg::SP_PI_PROP: omega <= 31'(omega_clamp);
        spll_pkg::SP_FRQ:     freq  <= 23'((prod + (96'd1 << 37)) >> 38);
        spll_pkg::SP_PH_WT:   wt    <= prod[63:0];
        spll_pkg::SP_DUTY:    duty  <= 11'(duty_sum >>> 30);
        default: begin
          wt <= wt;
        end
      endcase
    end
  end

endmodule

[src/spll_checker.sv]
// ----------------------------------------------------------------------------
// SOGI PLL port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "sogi_single_phase_pll_assert.svh"

module spll_checker (
  input logic         clk,
  input logic         rst,
  input logic [15:0]  s_tdata,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [167:0] m_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // A stalled result keeps its value.
  `SPLL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // After a sample transfer the block is busy computing.
  `SPLL_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready stayed high after accept")

  // A new result only appears at the end of a computation.
  `SPLL_ASSERT(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without computation")

  // The register port never inserts wait states.
  `SPLL_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind sogi_single_phase_pll spll_checker u_spll_checker (.*);

[test/sogi_single_phase_pll_checker.sv]
// ----------------------------------------------------------------------------
// SOGI PLL result checker
// Watches the sample, result and register channels and keeps its own model
// of the filter, phase detector, PI loop and phase accumulator. Each sample
// transfer queues one predicted result. Each result transfer is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sogi_single_phase_pll_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic [15:0]  s_tdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);

  localparam int TABLE_BITS = 10;
  localparam longint INTEG_MAX = 64'sd263535892;
  localparam longint W_MAX = 64'sd1712983302;
  localparam longint W_MIN = 64'sd1185911518;

  typedef struct {
    logic [31:0] inphase;
    logic [31:0] quadrature;
    logic [31:0] error;
    logic [31:0] angle;
    logic [22:0] freq;
    logic [10:0] duty;
  } pll_result_t;

  pll_result_t result_q[$];

  // Register copies, tracked from the write channel.
  logic signed [31:0] b0, b1, a1, a2;
  logic [31:0] kp, ki, ts;
  logic [30:0] w0;

  // Loop state.
  longint sd1, sd2, vd1, vd2, qd1, qd2, integ;
  logic [31:0] theta;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quarter-wave folded Taylor sine of a truncated phase, Q2.30.
  function automatic longint sine_of(input logic [31:0] ph);
    logic [31:0] p;
    longint unsigned r, x, x2, t, s;
    p = (ph >> (32 - TABLE_BITS)) << (32 - TABLE_BITS);
    r = {34'd0, p[29:0]};
    if (p[30]) r = 64'd1073741824 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 110;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    return p[31] ? -longint'(s) : longint'(s);
  endfunction

  // Advance the loop by one grid sample and queue what it must produce.
  task automatic predict_sample(input logic [15:0] raw);
    longint x, acc, vp, qvp, sn, cs, err, prop, omega;
    longint unsigned mag, gain_ts, freq;
    logic [127:0] wide;
    pll_result_t r;
    x = longint'($signed(raw));
    acc = longint'(b0) * (x - sd2)
        - ((longint'(a1) * vd1) >>> 16)
        - ((longint'(a2) * vd2) >>> 16);
    vp = clamp32((acc + 8192) >>> 14);
    acc = longint'(b1) * (x + 2 * sd1 + sd2)
        - ((longint'(a1) * qd1) >>> 16)
        - ((longint'(a2) * qd2) >>> 16);
    qvp = clamp32((acc + 8192) >>> 14);
    sd2 = sd1; sd1 = x;
    vd2 = vd1; vd1 = vp;
    qd2 = qd1; qd1 = qvp;

    sn = sine_of(theta);
    cs = sine_of(theta + 32'h4000_0000);
    err = clamp32((vp * cs + qvp * sn) >>> 30);
    mag = (err < 0) ? longint'(-err) : longint'(err);

    // Integral path, clamped to plus or minus 62.83 rad/s.
    gain_ts = longint'(ki) * longint'(ts);
    wide = ({64'd0, gain_ts} * {64'd0, mag}) >> 56;
    integ = (err < 0) ? integ - longint'(wide[63:0]) : integ + longint'(wide[63:0]);
    if (integ > INTEG_MAX) integ = INTEG_MAX;
    else if (integ < -INTEG_MAX) integ = -INTEG_MAX;

    prop = longint'((longint'(kp) * mag) >> 24);
    if (err < 0) prop = -prop;
    omega = longint'(w0) + prop + integ;
    if (omega > W_MAX) omega = W_MAX;
    else if (omega < W_MIN) omega = W_MIN;

    freq = (longint'(omega) * 64'd683565276 + (64'd1 << 37)) >> 38;
    wide = ({64'd0, omega * longint'(ts)} * 128'd683565276) >> 54;
    theta = theta + wide[31:0];
    sn = sine_of(theta);

    r.inphase = vp[31:0];
    r.quadrature = qvp[31:0];
    r.error = err[31:0];
    r.angle = theta;
    r.freq = freq[22:0];
    r.duty = 11'((64'sd1073741824000 + 800 * sn) >>> 30);
    result_q.push_back(r);
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  task automatic compare_result(input logic [167:0] d);
    pll_result_t e;
    if (result_q.size() == 0) begin
      report("result with no sample waiting", d[31:0], 32'd0);
    end else begin
      e = result_q.pop_front();
      if (d[31:0] !== e.inphase) report("inphase_out", d[31:0], e.inphase);
      if (d[63:32] !== e.quadrature) report("quadrature_out", d[63:32], e.quadrature);
      if (d[95:64] !== e.error) report("phase_error", d[95:64], e.error);
      if (d[127:96] !== e.angle) report("phase_angle", d[127:96], e.angle);
      if (d[150:128] !== e.freq) report("frequency_hz", 32'(d[150:128]), 32'(e.freq));
      if (d[161:151] !== e.duty) report("duty_compare", 32'(d[161:151]), 32'(e.duty));
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      b0 <= spll_pkg::RST_COEF_B0; b1 <= spll_pkg::RST_COEF_B1;
      a1 <= spll_pkg::RST_COEF_A1; a2 <= spll_pkg::RST_COEF_A2;
      kp <= spll_pkg::RST_PROP_GAIN; ki <= spll_pkg::RST_INTEG_GAIN;
      ts <= spll_pkg::RST_SAMPLE_PERIOD;
      w0 <= spll_pkg::RST_NOMINAL_OMEGA;
      sd1 = 0; sd2 = 0; vd1 = 0; vd2 = 0; qd1 = 0; qd2 = 0; integ = 0;
      theta = '0;
      result_q.delete();
    end else begin
      // Register write transfer.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          spll_pkg::REG_COEF_B0:       b0 <= pwdata;
          spll_pkg::REG_COEF_B1:       b1 <= pwdata;
          spll_pkg::REG_COEF_A1:       a1 <= pwdata;
          spll_pkg::REG_COEF_A2:       a2 <= pwdata;
          spll_pkg::REG_PROP_GAIN:     kp <= pwdata;
          spll_pkg::REG_INTEG_GAIN:    ki <= pwdata;
          spll_pkg::REG_SAMPLE_PERIOD: ts <= pwdata;
          spll_pkg::REG_NOMINAL_OMEGA: w0 <= pwdata[30:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_sample(s_tdata);
      if (m_tvalid && m_tready) compare_result(m_tdata);
    end
    pending <= result_q.size();
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// SOGI PLL testbench
// Drives grid samples in bursts through several register settings, with a
// stalling result consumer, and leaves prediction and comparison to the
// checker. Gives the verdict once every result has been seen.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [15:0]  s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;
  logic         hold_req = 1'b0;
  int           burst_left = 0;

  always #6 clk = ~clk;

  sogi_single_phase_pll u_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sogi_single_phase_pll_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Result consumer: alternates between always ready and random stalls,
  // with one long hold-off on request.
  always @(posedge clk) begin
    static int mode_left = 0;
    static bit choppy = 1'b0;
    static int hold_left = 0;
    static bit hold_seen = 1'b0;
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 4000;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 400);
      choppy = $urandom_range(0, 1);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    static int idle = 0;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle = 0;
    else
      idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("FAIL sogi_single_phase_pll");
      $finish;
    end
  end

  // One register write transfer, after which the bus returns to idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] c0, c1, c2, c3, g_p, g_i, per, w);
    write_reg(spll_pkg::REG_COEF_B0, c0);
    write_reg(spll_pkg::REG_COEF_B1, c1);
    write_reg(spll_pkg::REG_COEF_A1, c2);
    write_reg(spll_pkg::REG_COEF_A2, c3);
    write_reg(spll_pkg::REG_PROP_GAIN, g_p);
    write_reg(spll_pkg::REG_INTEG_GAIN, g_i);
    write_reg(spll_pkg::REG_SAMPLE_PERIOD, per);
    write_reg(spll_pkg::REG_NOMINAL_OMEGA, w);
  endtask

  // One sample transfer; bursts sometimes end in a random gap.
  task automatic send_sample(input logic [15:0] v);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 1) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 1100)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every queued result has been seen, plus a short settle.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly a triangle wave of random amplitude and period with noise,
  // sometimes a fully random sample.
  task automatic send_wave(input int count);
    int amp, period, k, v;
    amp = $urandom_range(2000, 32767);
    period = $urandom_range(8, 60);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        amp = $urandom_range(2000, 32767);
        period = $urandom_range(8, 60);
      end
      if ($urandom_range(0, 4) == 0) begin
        send_sample(16'($urandom));
      end else begin
        k = i % period;
        v = (k < period / 2) ? (-amp + (4 * amp * k) / period)
                             : (3 * amp - (4 * amp * k) / period);
        v = v + $signed($urandom_range(0, 400)) - 200;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        send_sample(16'(v));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: field extremes and single-bit patterns.
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h4000);
    send_sample(16'hC000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_wave(60);
    hold_req <= 1'b1;
    send_wave(120);
    drain();

    // Largest register values: filter and error saturate, omega clamps high.
    load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_wave(40);
    drain();

    // Smallest values: zero sample period freezes integrator and phase.
    load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_wave(40);
    drain();

    // Realistic filter with random loop gains and period.
    load_settings(spll_pkg::RST_COEF_B0, spll_pkg::RST_COEF_B1,
                  spll_pkg::RST_COEF_A1, spll_pkg::RST_COEF_A2,
                  $urandom_range(0, 32'h0400_0000), $urandom,
                  $urandom_range(40000, 200000), 32'(spll_pkg::RST_NOMINAL_OMEGA));
    send_wave(150);
    drain();

    // Back to the reset tuning for a long locked run.
    load_settings(spll_pkg::RST_COEF_B0, spll_pkg::RST_COEF_B1,
                  spll_pkg::RST_COEF_A1, spll_pkg::RST_COEF_A2,
                  spll_pkg::RST_PROP_GAIN, spll_pkg::RST_INTEG_GAIN,
                  spll_pkg::RST_SAMPLE_PERIOD, 32'(spll_pkg::RST_NOMINAL_OMEGA));
    send_wave(170);
    drain();
    repeat (1200) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS sogi_single_phase_pll");
    end else begin
      $display("FAIL sogi_single_phase_pll");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/spll_pkg.sv
src/spll_mul.sv
src/spll_div.sv
src/sogi_single_phase_pll.sv
src/spll_checker.sv
test/sogi_single_phase_pll_checker.sv
test/tb.sv
